// ===== src/ortov_pkg.sv =====
// Package for the oriented rectangle overlap test: field widths, sine table
// constants and the stage records that travel down the pipeline cells.
// No dependencies.
package ortov_pkg;

   localparam int COORD_WIDTH = 24;
   localparam int HALF_WIDTH  = 22;
   localparam int ANGLE_WIDTH = 16;
   localparam int TRIG_WIDTH  = 17;
   localparam int REQ_BITS    = 216;
   localparam int REQ_TDATA_WIDTH = 216;
   localparam int RSP_TDATA_WIDTH = 8;

   localparam int SINE_TABLE_DEPTH_DEFAULT = 1024;

   // Quarter turn in radians with 30 fraction bits.
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam int ONE_Q15 = 32768;

   // Taylor series divisors (2n)(2n+1) for n = 1..12.
   localparam longint unsigned TAYLOR_DIV [12] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
      64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600};

   // Request fields, first field in the lowest bits.
   typedef struct packed {
      logic        [ANGLE_WIDTH-1:0] second_angle;
      logic        [HALF_WIDTH-1:0]  second_half_height;
      logic        [HALF_WIDTH-1:0]  second_half_width;
      logic signed [COORD_WIDTH-1:0] second_center_y;
      logic signed [COORD_WIDTH-1:0] second_center_x;
      logic        [ANGLE_WIDTH-1:0] first_angle;
      logic        [HALF_WIDTH-1:0]  first_half_height;
      logic        [HALF_WIDTH-1:0]  first_half_width;
      logic signed [COORD_WIDTH-1:0] first_center_y;
      logic signed [COORD_WIDTH-1:0] first_center_x;
   } req_type;

   typedef struct packed {
      logic [HALF_WIDTH-1:0] hw_a;
      logic [HALF_WIDTH-1:0] hh_a;
      logic [HALF_WIDTH-1:0] hw_b;
      logic [HALF_WIDTH-1:0] hh_b;
   } halves_type;

   typedef struct packed {
      logic both_zero;
      logic aabb_hit;
   } flags_type;

   typedef struct packed {
      logic signed [TRIG_WIDTH-1:0] ca;
      logic signed [TRIG_WIDTH-1:0] sa;
      logic signed [TRIG_WIDTH-1:0] cb;
      logic signed [TRIG_WIDTH-1:0] sb;
      logic signed [COORD_WIDTH:0]  dx;
      logic signed [COORD_WIDTH:0]  dy;
      halves_type                   halves;
      flags_type                    flags;
   } trig_stage_type;

   typedef struct packed {
      logic signed [41:0] a_dx_c;
      logic signed [41:0] a_dy_s;
      logic signed [41:0] a_dy_c;
      logic signed [41:0] a_dx_s;
      logic signed [41:0] b_dx_c;
      logic signed [41:0] b_dy_s;
      logic signed [41:0] b_dy_c;
      logic signed [41:0] b_dx_s;
      logic signed [33:0] pcc;
      logic signed [33:0] pss;
      logic signed [33:0] psc;
      logic signed [33:0] pcs;
      halves_type         halves;
      flags_type          flags;
   } prod_stage_type;

   typedef struct packed {
      logic [41:0] ca_x;
      logic [41:0] ca_y;
      logic [41:0] cb_x;
      logic [41:0] cb_y;
      logic [31:0] p_mag;
      logic [31:0] q_mag;
      halves_type  halves;
      flags_type   flags;
   } sum_stage_type;

   typedef struct packed {
      logic [41:0] ca_x;
      logic [41:0] ca_y;
      logic [41:0] cb_x;
      logic [41:0] cb_y;
      logic [53:0] hwb_p;
      logic [53:0] hhb_q;
      logic [53:0] hwb_q;
      logic [53:0] hhb_p;
      logic [53:0] hwa_p;
      logic [53:0] hha_q;
      logic [53:0] hwa_q;
      logic [53:0] hha_p;
      halves_type  halves;
      flags_type   flags;
   } ext_stage_type;

   typedef struct packed {
      logic [41:0] ca_x;
      logic [41:0] ca_y;
      logic [41:0] cb_x;
      logic [41:0] cb_y;
      logic [56:0] lim_ax;
      logic [56:0] lim_ay;
      logic [56:0] lim_bx;
      logic [56:0] lim_by;
      flags_type   flags;
   } lim_stage_type;

   typedef struct packed {
      logic overlap;
   } rsp_type;

endpackage

// ===== src/ortov_cell.sv =====
// One pipeline cell of the overlap test: a valid flag and a stage record,
// handed to the next cell whenever that cell can take it.
// Depends on nothing but the record type given as a parameter.
module ortov_cell #(
   parameter type data_type = logic
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  data_type in_data,
   output logic     in_ready,
   output logic     out_valid,
   output data_type out_data,
   input  logic     out_ready
);

   logic     valid_ff;
   logic     valid_in;
   data_type data_ff;

   // The cell takes a new record when it is empty or its record leaves now.
   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

endmodule

// ===== src/ortov_sine_rom.sv =====
// Constant sine table of the overlap test, built at elaboration, giving the
// sine and cosine of a binary angle in Q1.15. Depends on ortov_pkg.
module ortov_sine_rom #(
   parameter int SINE_TABLE_DEPTH = ortov_pkg::SINE_TABLE_DEPTH_DEFAULT
) (
   input  logic [ortov_pkg::ANGLE_WIDTH-1:0]        angle,
   output logic signed [ortov_pkg::TRIG_WIDTH-1:0] sin_value,
   output logic signed [ortov_pkg::TRIG_WIDTH-1:0] cos_value
);

   localparam int IndexWidth = $clog2(SINE_TABLE_DEPTH);
   localparam int DepthWidth = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int ProdWidth  = ortov_pkg::ANGLE_WIDTH + DepthWidth;
   localparam longint unsigned Depth = longint'(SINE_TABLE_DEPTH);

   typedef logic signed [ortov_pkg::TRIG_WIDTH-1:0] rom_type [SINE_TABLE_DEPTH];

   function automatic rom_type build_rom();
      rom_type           rom;
      longint unsigned   x;
      longint unsigned   x2;
      longint unsigned   term;
      longint unsigned   q;
      longint unsigned   r;
      longint unsigned   m;
      longint            sum;
      for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
         q = (64'd4 * longint'(k)) / Depth;
         r = 64'd4 * longint'(k) - q * Depth;
         m = q[0] ? Depth - r : r;
         x = (ortov_pkg::HALF_PI_Q30 * m + Depth / 2) / Depth;
         x2 = (x * x) >> 30;
         term = x;
         sum = longint'(x);
         for (int n = 1; n <= 12; n++) begin
            term = ((term * x2) >> 30) / ortov_pkg::TAYLOR_DIV[n-1];
            if (n % 2 == 1) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         sum = (sum + 64'sd16384) >>> 15;
         if (sum > ortov_pkg::ONE_Q15) begin
            sum = ortov_pkg::ONE_Q15;
         end
         rom[k] = q[1] ? -ortov_pkg::TRIG_WIDTH'(sum) : ortov_pkg::TRIG_WIDTH'(sum);
      end
      return rom;
   endfunction

   localparam rom_type SineRom = build_rom();

   logic [ortov_pkg::ANGLE_WIDTH-1:0] cos_angle;
   logic [ProdWidth-1:0]              sin_prod;
   logic [ProdWidth-1:0]              cos_prod;

   // The cosine is the sine a quarter turn further on.
   assign cos_angle = angle + ortov_pkg::ANGLE_WIDTH'(16384);
   assign sin_prod  = ProdWidth'(angle) * ProdWidth'(SINE_TABLE_DEPTH);
   assign cos_prod  = ProdWidth'(cos_angle) * ProdWidth'(SINE_TABLE_DEPTH);
   assign sin_value = SineRom[sin_prod[ortov_pkg::ANGLE_WIDTH +: IndexWidth]];
   assign cos_value = SineRom[cos_prod[ortov_pkg::ANGLE_WIDTH +: IndexWidth]];

endmodule

// ===== src/oriented_rect_overlap_test.sv =====
// Oriented rectangle overlap test: a row of seven pipeline cells.
// Throughput: one rectangle pair per cycle; each cell moves on as soon as the
// next one frees, so a waiting result stalls requests only once all seven cells are full.
// Reset clears the valid flag of every cell; the table is constant.
// Depends on ortov_pkg, ortov_cell and ortov_sine_rom.
module oriented_rect_overlap_test #(
   parameter int SINE_TABLE_DEPTH = ortov_pkg::SINE_TABLE_DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // first_center_x, first_center_y, first_half_width, first_half_height,
   // first_angle, second_center_x, second_center_y, second_half_width,
   // second_half_height, second_angle
   input  logic [ortov_pkg::REQ_TDATA_WIDTH-1:0] req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // overlap, then seven zero bits
   output logic [ortov_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata
);

   logic [6:0] vld;
   logic [6:0] rdy;

   ortov_pkg::req_type        req_in, req_q;
   ortov_pkg::trig_stage_type trig_in, trig_q;
   ortov_pkg::prod_stage_type prod_in, prod_q;
   ortov_pkg::sum_stage_type  sum_in, sum_q;
   ortov_pkg::ext_stage_type  ext_in, ext_q;
   ortov_pkg::lim_stage_type  lim_in, lim_q;
   ortov_pkg::rsp_type        rsp_in, rsp_q;

   assign req_in = ortov_pkg::req_type'(req_tdata[ortov_pkg::REQ_BITS-1:0]);

   ortov_cell #(.data_type(ortov_pkg::req_type)) u_cell_req (
      .clock(clock), .reset(reset), .in_valid(req_tvalid), .in_data(req_in),
      .in_ready(req_tready), .out_valid(vld[0]), .out_data(req_q), .out_ready(rdy[1]));

   // Stage 1: table lookups, centre offsets and the axis-aligned test.
   logic signed [ortov_pkg::TRIG_WIDTH-1:0] sa, ca, sb, cb;
   logic signed [25:0] ax_lo, ax_hi, ay_lo, ay_hi, bx_lo, bx_hi, by_lo, by_hi;

   ortov_sine_rom #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_rom_a (
      .angle(req_q.first_angle), .sin_value(sa), .cos_value(ca));
   ortov_sine_rom #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_rom_b (
      .angle(req_q.second_angle), .sin_value(sb), .cos_value(cb));

   always_comb begin
      ax_hi = 26'(req_q.first_center_x) + 26'(req_q.first_half_width);
      ax_lo = 26'(req_q.first_center_x) - 26'(req_q.first_half_width);
      ay_hi = 26'(req_q.first_center_y) + 26'(req_q.first_half_height);
      ay_lo = 26'(req_q.first_center_y) - 26'(req_q.first_half_height);
      bx_hi = 26'(req_q.second_center_x) + 26'(req_q.second_half_width);
      bx_lo = 26'(req_q.second_center_x) - 26'(req_q.second_half_width);
      by_hi = 26'(req_q.second_center_y) + 26'(req_q.second_half_height);
      by_lo = 26'(req_q.second_center_y) - 26'(req_q.second_half_height);
      trig_in.ca = ca;
      trig_in.sa = sa;
      trig_in.cb = cb;
      trig_in.sb = sb;
      trig_in.dx = 25'(req_q.second_center_x) - 25'(req_q.first_center_x);
      trig_in.dy = 25'(req_q.second_center_y) - 25'(req_q.first_center_y);
      trig_in.halves.hw_a = req_q.first_half_width;
      trig_in.halves.hh_a = req_q.first_half_height;
      trig_in.halves.hw_b = req_q.second_half_width;
      trig_in.halves.hh_b = req_q.second_half_height;
      trig_in.flags.both_zero = (req_q.first_angle == '0) && (req_q.second_angle == '0);
      trig_in.flags.aabb_hit = !(ax_hi <= bx_lo || bx_hi <= ax_lo ||
                                 ay_hi <= by_lo || by_hi <= ay_lo);
   end

   ortov_cell #(.data_type(ortov_pkg::trig_stage_type)) u_cell_trig (
      .clock(clock), .reset(reset), .in_valid(vld[0]), .in_data(trig_in),
      .in_ready(rdy[1]), .out_valid(vld[1]), .out_data(trig_q), .out_ready(rdy[2]));

   // Stage 2: each frame's rotation applied to the offset, and the products
   // that give the cosine and sine of the angle between the frames.
   always_comb begin
      prod_in.a_dx_c = 42'(trig_q.ca) * 42'(trig_q.dx);
      prod_in.a_dy_s = 42'(trig_q.sa) * 42'(trig_q.dy);
      prod_in.a_dy_c = 42'(trig_q.ca) * 42'(trig_q.dy);
      prod_in.a_dx_s = 42'(trig_q.sa) * 42'(trig_q.dx);
      prod_in.b_dx_c = 42'(trig_q.cb) * 42'(trig_q.dx);
      prod_in.b_dy_s = 42'(trig_q.sb) * 42'(trig_q.dy);
      prod_in.b_dy_c = 42'(trig_q.cb) * 42'(trig_q.dy);
      prod_in.b_dx_s = 42'(trig_q.sb) * 42'(trig_q.dx);
      prod_in.pcc    = 34'(trig_q.ca) * 34'(trig_q.cb);
      prod_in.pss    = 34'(trig_q.sa) * 34'(trig_q.sb);
      prod_in.psc    = 34'(trig_q.sa) * 34'(trig_q.cb);
      prod_in.pcs    = 34'(trig_q.ca) * 34'(trig_q.sb);
      prod_in.halves = trig_q.halves;
      prod_in.flags  = trig_q.flags;
   end

   ortov_cell #(.data_type(ortov_pkg::prod_stage_type)) u_cell_prod (
      .clock(clock), .reset(reset), .in_valid(vld[1]), .in_data(prod_in),
      .in_ready(rdy[2]), .out_valid(vld[2]), .out_data(prod_q), .out_ready(rdy[3]));

   // Stage 3: magnitudes of the rotated centre offsets and of the relative
   // cosine and sine; only magnitudes matter for the extents below.
   logic signed [42:0] cax, cay, cbx, cby;
   logic signed [34:0] p_val, q_val;

   always_comb begin
      cax   = 43'(prod_q.a_dx_c) + 43'(prod_q.a_dy_s);
      cay   = 43'(prod_q.a_dy_c) - 43'(prod_q.a_dx_s);
      cbx   = 43'(prod_q.b_dx_c) + 43'(prod_q.b_dy_s);
      cby   = 43'(prod_q.b_dy_c) - 43'(prod_q.b_dx_s);
      p_val = 35'(prod_q.pcc) + 35'(prod_q.pss);
      q_val = 35'(prod_q.psc) - 35'(prod_q.pcs);
      sum_in.ca_x  = 42'((cax < 0) ? -cax : cax);
      sum_in.ca_y  = 42'((cay < 0) ? -cay : cay);
      sum_in.cb_x  = 42'((cbx < 0) ? -cbx : cbx);
      sum_in.cb_y  = 42'((cby < 0) ? -cby : cby);
      sum_in.p_mag = 32'((p_val < 0) ? -p_val : p_val);
      sum_in.q_mag = 32'((q_val < 0) ? -q_val : q_val);
      sum_in.halves = prod_q.halves;
      sum_in.flags  = prod_q.flags;
   end

   ortov_cell #(.data_type(ortov_pkg::sum_stage_type)) u_cell_sum (
      .clock(clock), .reset(reset), .in_valid(vld[2]), .in_data(sum_in),
      .in_ready(rdy[3]), .out_valid(vld[3]), .out_data(sum_q), .out_ready(rdy[4]));

   // Stage 4: half extents of each rectangle's corners seen in the other frame.
   always_comb begin
      ext_in.ca_x  = sum_q.ca_x;
      ext_in.ca_y  = sum_q.ca_y;
      ext_in.cb_x  = sum_q.cb_x;
      ext_in.cb_y  = sum_q.cb_y;
      ext_in.hwb_p = 54'(sum_q.halves.hw_b) * 54'(sum_q.p_mag);
      ext_in.hhb_q = 54'(sum_q.halves.hh_b) * 54'(sum_q.q_mag);
      ext_in.hwb_q = 54'(sum_q.halves.hw_b) * 54'(sum_q.q_mag);
      ext_in.hhb_p = 54'(sum_q.halves.hh_b) * 54'(sum_q.p_mag);
      ext_in.hwa_p = 54'(sum_q.halves.hw_a) * 54'(sum_q.p_mag);
      ext_in.hha_q = 54'(sum_q.halves.hh_a) * 54'(sum_q.q_mag);
      ext_in.hwa_q = 54'(sum_q.halves.hw_a) * 54'(sum_q.q_mag);
      ext_in.hha_p = 54'(sum_q.halves.hh_a) * 54'(sum_q.p_mag);
      ext_in.halves = sum_q.halves;
      ext_in.flags  = sum_q.flags;
   end

   ortov_cell #(.data_type(ortov_pkg::ext_stage_type)) u_cell_ext (
      .clock(clock), .reset(reset), .in_valid(vld[3]), .in_data(ext_in),
      .in_ready(rdy[4]), .out_valid(vld[4]), .out_data(ext_q), .out_ready(rdy[5]));

   // Stage 5: separation limit on each axis, the base half size plus the
   // other rectangle's extent along that axis.
   always_comb begin
      lim_in.ca_x   = ext_q.ca_x;
      lim_in.ca_y   = ext_q.ca_y;
      lim_in.cb_x   = ext_q.cb_x;
      lim_in.cb_y   = ext_q.cb_y;
      lim_in.lim_ax = 57'({ext_q.halves.hw_a, 30'b0}) + 57'(ext_q.hwb_p) + 57'(ext_q.hhb_q);
      lim_in.lim_ay = 57'({ext_q.halves.hh_a, 30'b0}) + 57'(ext_q.hwb_q) + 57'(ext_q.hhb_p);
      lim_in.lim_bx = 57'({ext_q.halves.hw_b, 30'b0}) + 57'(ext_q.hwa_p) + 57'(ext_q.hha_q);
      lim_in.lim_by = 57'({ext_q.halves.hh_b, 30'b0}) + 57'(ext_q.hwa_q) + 57'(ext_q.hha_p);
      lim_in.flags  = ext_q.flags;
   end

   ortov_cell #(.data_type(ortov_pkg::lim_stage_type)) u_cell_lim (
      .clock(clock), .reset(reset), .in_valid(vld[4]), .in_data(lim_in),
      .in_ready(rdy[5]), .out_valid(vld[5]), .out_data(lim_q), .out_ready(rdy[6]));

   // Stage 6: an axis separates when the centre offset reaches its limit,
   // so touching edges count as separate.
   logic sep_any;

   always_comb begin
      sep_any = (57'({lim_q.ca_x, 15'b0}) >= lim_q.lim_ax) ||
                (57'({lim_q.ca_y, 15'b0}) >= lim_q.lim_ay) ||
                (57'({lim_q.cb_x, 15'b0}) >= lim_q.lim_bx) ||
                (57'({lim_q.cb_y, 15'b0}) >= lim_q.lim_by);
      rsp_in.overlap = lim_q.flags.both_zero ? lim_q.flags.aabb_hit : !sep_any;
   end

   ortov_cell #(.data_type(ortov_pkg::rsp_type)) u_cell_rsp (
      .clock(clock), .reset(reset), .in_valid(vld[5]), .in_data(rsp_in),
      .in_ready(rdy[6]), .out_valid(vld[6]), .out_data(rsp_q), .out_ready(rsp_tready));

   assign rsp_tvalid = vld[6];
   assign rsp_tdata  = {7'b0, rsp_q.overlap};
   assign rdy[0]     = req_tready;

endmodule
